### rtl/mpmv_pkg.sv
// ----------------------------------------------------------------------------
// mpmv_pkg
// Shared types, constants and helpers for the max-plus matrix-vector block.
// ----------------------------------------------------------------------------
package mpmv_pkg;

	localparam int MAX_DIM    = 8;
	localparam int IDX_W      = 3;
	localparam int SIZE_W     = 4;
	localparam int DATA_W     = 32;
	localparam int WADDR_W    = $clog2(MAX_DIM * MAX_DIM);
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

	localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = SIZE_W'(MAX_DIM);
	localparam logic [SIZE_W-1:0] DIM_MAX           = SIZE_W'(MAX_DIM);

	localparam logic signed [DATA_W-1:0] FLOOR_VALUE = 32'sh8000_0001;
	localparam logic signed [DATA_W-1:0] S32_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN     = 32'sh8000_0000;

	// register index, taken from the word address
	localparam logic REG_ACTIVE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		CMD_WEIGHT,
		CMD_ELEM,
		CMD_RUN
	} cmd_kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} back_state_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [DATA_W-1:0]  value;
		logic [IDX_W-1:0]          rows_m1;
		logic [IDX_W-1:0]          dim_m1;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]          row;
		logic signed [DATA_W-1:0]  value;
		logic                      last;
	} result_t;

	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1]) begin
			return s[DATA_W] ? S32_MIN : S32_MAX;
		end
		return s[DATA_W-1:0];
	endfunction

endpackage

### rtl/mpmv_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mpmv_cmd_fifo
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module mpmv_cmd_fifo
	import mpmv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic cmd_full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic cmd_empty
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_PTR_W:0]   count_q;

	assign cmd_full  = (count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign cmd_empty = (count_q == '0);
	assign rd_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/mpmv_front.sv
// ----------------------------------------------------------------------------
// mpmv_front
// Accepts input transactions and turns them into back-end commands:
// weight write, vector element, or vector element that starts a product run.
// ----------------------------------------------------------------------------
module mpmv_front
	import mpmv_pkg::*;
(
	input  logic                     push,
	output logic                     full,
	input  logic                     mode,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         column_index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	input  logic [SIZE_W-1:0]        rows_wanted,
	input  logic [SIZE_W-1:0]        active_size,
	input  logic                     cmd_full,
	output logic                     cmd_push,
	output cmd_t                     cmd
);

	logic [SIZE_W-1:0] eff_dim;
	logic [SIZE_W-1:0] rows;

	always_comb begin
		if (active_size == '0) begin
			eff_dim = SIZE_W'(1);
		end else if (active_size > DIM_MAX) begin
			eff_dim = DIM_MAX;
		end else begin
			eff_dim = active_size;
		end
		rows = (rows_wanted < eff_dim) ? rows_wanted : eff_dim;

		cmd.row     = row_index;
		cmd.col     = column_index;
		cmd.value   = value;
		cmd.dim_m1  = IDX_W'(eff_dim - 1'b1);
		cmd.rows_m1 = IDX_W'(rows - 1'b1);
		if (!mode) begin
			cmd.kind = CMD_WEIGHT;
		end else if (is_last && (rows != '0)) begin
			cmd.kind = CMD_RUN;
		end else begin
			cmd.kind = CMD_ELEM;
		end
	end

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;

endmodule

### rtl/mpmv_back.sv
// ----------------------------------------------------------------------------
// mpmv_back
// Executes commands: stores weights and vector elements, and on a run walks
// the weight memory row by row through a three-stage read/saturated-add/max pipe.
// Results go into an output queue; row issue is gated by reserved slots.
// ----------------------------------------------------------------------------
module mpmv_back
	import mpmv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_empty,
	input  cmd_t                     cmd,
	output logic                     cmd_pop,
	output logic                     empty,
	input  logic                     pop,
	output result_t                  head
);

	back_state_t state_q, state_d;

	logic [DATA_W-1:0]        wmem [MAX_DIM*MAX_DIM];
	logic signed [DATA_W-1:0] vec_q [MAX_DIM];

	logic [IDX_W-1:0] row_q, row_d;
	logic [IDX_W-1:0] col_q, col_d;
	logic [IDX_W-1:0] rows_m1_q, rows_m1_d;
	logic [IDX_W-1:0] dim_m1_q, dim_m1_d;

	logic issue;
	logic wr_weight;
	logic wr_elem;

	// stage 1: memory read and vector element
	logic                     v_s1;
	logic signed [DATA_W-1:0] rd_s1;
	logic signed [DATA_W-1:0] vec_s1;
	logic                     first_s1, endc_s1, lastrow_s1;
	logic [IDX_W-1:0]         row_s1;
	// stage 2: saturated sum
	logic                     v_s2;
	logic signed [DATA_W-1:0] sum_s2;
	logic                     first_s2, endc_s2, lastrow_s2;
	logic [IDX_W-1:0]         row_s2;
	// stage 3: running maximum
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W-1:0] acc_base;
	logic signed [DATA_W-1:0] acc_new;

	// output queue
	result_t               outq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] owr_ptr_q;
	logic [OUTQ_PTR_W-1:0] ord_ptr_q;
	logic [OUTQ_PTR_W:0]   ocount_q;
	logic [OUTQ_PTR_W:0]   resv_q;
	logic                  opush;
	logic                  opop;
	logic                  row_start;
	result_t               opush_data;

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		rows_m1_d = rows_m1_q;
		dim_m1_d  = dim_m1_q;
		cmd_pop   = 1'b0;
		issue     = 1'b0;
		wr_weight = 1'b0;
		wr_elem   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = !cmd_empty;
				if (!cmd_empty) begin
					case (cmd.kind)
						CMD_WEIGHT: wr_weight = 1'b1;
						CMD_ELEM:   wr_elem   = 1'b1;
						CMD_RUN: begin
							wr_elem   = 1'b1;
							state_d   = ST_RUN;
							row_d     = '0;
							col_d     = '0;
							rows_m1_d = cmd.rows_m1;
							dim_m1_d  = cmd.dim_m1;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				// a new row needs a free result slot
				issue = (col_q != '0) || (resv_q < (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
				if (issue) begin
					if (col_q == dim_m1_q) begin
						col_d = '0;
						if (row_q == rows_m1_q) begin
							state_d = ST_IDLE;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		row_q     <= row_d;
		col_q     <= col_d;
		rows_m1_q <= rows_m1_d;
		dim_m1_q  <= dim_m1_d;
	end

	// weight memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_weight) begin
			wmem[{cmd.row, cmd.col}] <= cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= wmem[{row_q, col_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_elem) begin
			vec_q[cmd.col] <= cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			vec_s1     <= vec_q[col_q];
			first_s1   <= (col_q == '0);
			endc_s1    <= (col_q == dim_m1_q);
			lastrow_s1 <= (row_q == rows_m1_q);
			row_s1     <= row_q;
		end
		if (v_s1) begin
			sum_s2     <= sat_add(rd_s1, vec_s1);
			first_s2   <= first_s1;
			endc_s2    <= endc_s1;
			lastrow_s2 <= lastrow_s1;
			row_s2     <= row_s1;
		end
		if (v_s2) begin
			acc_q <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		acc_base         = first_s2 ? FLOOR_VALUE : acc_q;
		acc_new          = (sum_s2 > acc_base) ? sum_s2 : acc_base;
		opush            = v_s2 && endc_s2;
		opush_data.row   = row_s2;
		opush_data.value = acc_new;
		opush_data.last  = lastrow_s2;
	end

	assign opop      = pop && !empty;
	assign empty     = (ocount_q == '0);
	assign head      = outq_q[ord_ptr_q];
	assign row_start = issue && (col_q == '0);

	always_ff @(posedge clk) begin
		if (opush) begin
			outq_q[owr_ptr_q] <= opush_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocount_q  <= '0;
			resv_q    <= '0;
		end else begin
			if (opush) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (opop) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			case ({opush, opop})
				2'b10:   ocount_q <= ocount_q + 1'b1;
				2'b01:   ocount_q <= ocount_q - 1'b1;
				default: ocount_q <= ocount_q;
			endcase
			// slots held by queued results and rows still in the pipe
			case ({row_start, opop})
				2'b10:   resv_q <= resv_q + 1'b1;
				2'b01:   resv_q <= resv_q - 1'b1;
				default: resv_q <= resv_q;
			endcase
		end
	end

endmodule

### rtl/max_plus_matrix_vector_product.sv
// ----------------------------------------------------------------------------
// max_plus_matrix_vector_product
// Max-plus matrix-vector product: weights and vector elements are written in,
// the last element triggers one result per row, each the maximum over active
// columns of the saturated sum weight + element, floored at -0x7FFFFFFF.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | push / full           | mode, row_index, column_index, value,
//            |                       | is_last, rows_wanted
//   result   | empty / pop           | out_row, row_maximum, last_result
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata (active_size)
//
// Weight and element transactions enter one per cycle into a 4-deep command
// queue while it is not full, and retire in the back end one per cycle while
// it is idle. A run makes rows * active_size weight memory reads, one per
// cycle while a result slot is free. Results wait in an 8-deep queue; a row
// is issued only with a free slot, so a stalled pop stalls the back end and
// then the input. No clearing pass after reset.
// ----------------------------------------------------------------------------
module max_plus_matrix_vector_product
	import mpmv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     mode,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         column_index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	input  logic [SIZE_W-1:0]        rows_wanted,
	output logic                     empty,
	input  logic                     pop,
	output logic [IDX_W-1:0]         out_row,
	output logic signed [DATA_W-1:0] row_maximum,
	output logic                     last_result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [SIZE_W-1:0] active_size_q;
	logic              cfg_wr;
	logic              cmd_full;
	logic              cmd_empty;
	logic              cmd_push;
	logic              cmd_pop;
	cmd_t              front_cmd;
	cmd_t              back_cmd;
	result_t           head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ACTIVE_SIZE) ? {{(32-SIZE_W){1'b0}}, active_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RESET;
		end else if (cfg_wr && (paddr[2] == REG_ACTIVE_SIZE)) begin
			active_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	mpmv_front u_front (
		.push         (push),
		.full         (full),
		.mode         (mode),
		.row_index    (row_index),
		.column_index (column_index),
		.value        (value),
		.is_last      (is_last),
		.rows_wanted  (rows_wanted),
		.active_size  (active_size_q),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd          (front_cmd)
	);

	mpmv_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_push),
		.wr_cmd    (front_cmd),
		.cmd_full  (cmd_full),
		.rd_en     (cmd_pop),
		.rd_cmd    (back_cmd),
		.cmd_empty (cmd_empty)
	);

	mpmv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign out_row     = head.row;
	assign row_maximum = head.value;
	assign last_result = head.last;

endmodule
